// ----- src/spip_pkg.sv -----
`default_nettype none
package spip_pkg;

  // Polygon and decision limits
  localparam int unsigned MAX_VERTICES    = 1024;
  localparam int unsigned ANGLE_TOLERANCE = 105;
  localparam int unsigned CNT_W           = $clog2(MAX_VERTICES + 1);

  // Datapath widths
  localparam int unsigned ANG_W   = 31;  // working angle, 2^-20 degree units
  localparam int unsigned VEC_W   = 36;  // CORDIC x/y and Q1.30 intermediates
  localparam int unsigned MUL_W   = 32;  // multiplier operand width
  localparam int unsigned LON_W   = 29;  // rotated longitude
  localparam int unsigned SUM_W   = 40;  // running angle sum
  localparam int unsigned LAT_W   = 28;
  localparam int unsigned LONIN_W = 30;
  localparam int unsigned STEP_W  = 5;

  localparam int unsigned CORDIC_STEPS = 27;

  // Angle constants
  localparam logic signed [ANG_W-1:0] DEG_FULL    = 31'sd377487360;
  localparam logic signed [ANG_W-1:0] DEG_HALF    = 31'sd188743680;
  localparam logic signed [ANG_W-1:0] DEG_QUARTER = 31'sd94371840;
  localparam logic signed [VEC_W-1:0] CORDIC_GAIN = 36'sd652032874;

  localparam logic signed [SUM_W:0] SUM_MAX = 41'sd549755813887;
  localparam logic signed [SUM_W:0] SUM_MIN = -41'sd549755813888;
  localparam logic signed [SUM_W:0] INSIDE_LIMIT =
    41'sd377487360 - 41'(ANGLE_TOLERANCE);

  typedef enum logic [3:0] {
    S_IDLE,
    S_ROT,
    S_ROT_WAIT,
    S_MUL,
    S_ACC,
    S_ATAN,
    S_ATAN_WAIT,
    S_UPDATE,
    S_CHECK,
    S_CLOSE,
    S_DECIDE,
    S_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic vectoring;
  } cordic_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [ANG_W-1:0] z;
  } cordic_rsp_t;

  // Arctangent of 2^-i in 2^-20 degree units
  function automatic logic signed [ANG_W-1:0] atan_step(input logic [STEP_W-1:0] i);
    logic signed [ANG_W-1:0] v;
    unique case (i)
      5'd0:  v = 31'sd47185920;
      5'd1:  v = 31'sd27855475;
      5'd2:  v = 31'sd14718068;
      5'd3:  v = 31'sd7471121;
      5'd4:  v = 31'sd3750058;
      5'd5:  v = 31'sd1876857;
      5'd6:  v = 31'sd938658;
      5'd7:  v = 31'sd469357;
      5'd8:  v = 31'sd234682;
      5'd9:  v = 31'sd117342;
      5'd10: v = 31'sd58671;
      5'd11: v = 31'sd29335;
      5'd12: v = 31'sd14668;
      5'd13: v = 31'sd7334;
      5'd14: v = 31'sd3667;
      5'd15: v = 31'sd1833;
      5'd16: v = 31'sd917;
      5'd17: v = 31'sd458;
      5'd18: v = 31'sd229;
      5'd19: v = 31'sd115;
      5'd20: v = 31'sd57;
      5'd21: v = 31'sd29;
      5'd22: v = 31'sd14;
      5'd23: v = 31'sd7;
      5'd24: v = 31'sd4;
      5'd25: v = 31'sd2;
      5'd26: v = 31'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ----- src/spip_cordic.sv -----
`default_nettype none
module spip_cordic import spip_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire cordic_req_t             req,
  input  wire logic signed [ANG_W-1:0] ang_in,
  input  wire logic signed [VEC_W-1:0] x_in,
  input  wire logic signed [VEC_W-1:0] y_in,
  output cordic_rsp_t                  rsp
);

  logic                    busy;
  logic                    vec;
  logic                    flip;
  logic [STEP_W-1:0]       iter;
  logic signed [VEC_W-1:0] x, y;
  logic signed [ANG_W-1:0] z;

  logic signed [ANG_W-1:0] r1, r2, r3, r4, r_red;
  logic                    flip_in;
  logic signed [VEC_W-1:0] xs, ys, nx, ny;
  logic signed [ANG_W-1:0] at, nz;

  // Reduce the rotation angle to [-90, 90] degrees
  always_comb begin
    r1 = (ang_in < 0) ? ang_in + DEG_FULL : ang_in;
    r2 = (r1 < 0) ? r1 + DEG_FULL : r1;
    r3 = (r2 >= DEG_FULL) ? r2 - DEG_FULL : r2;
    r4 = (r3 > DEG_HALF) ? r3 - DEG_FULL : r3;
    flip_in = 1'b0;
    r_red = r4;
    if (r4 > DEG_QUARTER) begin
      r_red = r4 - DEG_HALF;
      flip_in = 1'b1;
    end else if (r4 < -DEG_QUARTER) begin
      r_red = r4 + DEG_HALF;
      flip_in = 1'b1;
    end
  end

  // One micro-rotation
  always_comb begin
    xs = x >>> iter;
    ys = y >>> iter;
    at = atan_step(iter);
    nx = x;
    ny = y;
    nz = z;
    if (!vec) begin
      if (z >= 0) begin
        nx = x - ys; ny = y + xs; nz = z - at;
      end else begin
        nx = x + ys; ny = y - xs; nz = z + at;
      end
    end else if (y > 0) begin
      nx = x + ys; ny = y - xs; nz = z + at;
    end else if (y < 0) begin
      nx = x - ys; ny = y + xs; nz = z - at;
    end
  end

  // Load, iterate, then finish with quadrant fix or clamp
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      rsp.done <= 1'b0;
      iter     <= '0;
    end else begin
      rsp.done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
        iter <= '0;
        vec  <= req.vectoring;
        flip <= flip_in;
        if (req.vectoring) begin
          if (x_in < 0) begin
            x <= -x_in;
            y <= -y_in;
            z <= (y_in >= 0) ? DEG_HALF : -DEG_HALF;
          end else begin
            x <= x_in;
            y <= y_in;
            z <= '0;
          end
        end else begin
          x <= CORDIC_GAIN;
          y <= '0;
          z <= r_red;
        end
      end else if (busy) begin
        x <= nx;
        y <= ny;
        z <= nz;
        iter <= iter + 1'b1;
        if (iter == STEP_W'(CORDIC_STEPS - 1)) begin
          busy     <= 1'b0;
          rsp.done <= 1'b1;
          if (!vec && flip) begin
            rsp.x <= -nx;
            rsp.y <= -ny;
          end else begin
            rsp.x <= nx;
            rsp.y <= ny;
          end
          if (nz > DEG_HALF)       rsp.z <= DEG_HALF;
          else if (nz < -DEG_HALF) rsp.z <= -DEG_HALF;
          else                     rsp.z <= nz;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- src/spherical_point_in_polygon.sv -----
`default_nettype none
// Per accepted vertex, with s_tready low until the sequencer is back in idle: four sin/cos
//   passes and one atan2 pass of the shared 27-step CORDIC unit, eight
//   products of the shared multiplier, then an update and a check state.
// The last vertex then closes the sum and decides (not for fewer than two vertices); its
//   result is raised in the output state, later while an older result waits on m_tready.
// One vertex is taken at a time; vertices past the limit skip to the check. Reset: rst (synchronous)
//   clears the sequencer, vertex count, sum and output valid.
module spherical_point_in_polygon import spip_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // point_lat[27:0], point_lon[57:28], vertex_lat[85:58], vertex_lon[115:86]
  input  wire logic [119:0] s_tdata,
  input  wire logic         s_tlast,   // last_vertex
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // inside_res[0], status[1]
  output logic [7:0]        m_tdata
);

  state_t state, state_next;

  logic signed [LAT_W-1:0]   v_lat, held_lat;
  logic signed [LONIN_W-1:0] v_lon, held_lon;
  logic                      last_r;
  logic [CNT_W-1:0]          cnt;
  logic signed [LON_W-1:0]   first_lon, prev_lon, lon_r;
  logic signed [SUM_W-1:0]   sum;
  logic [1:0]                jsel;
  logic [2:0]                k;
  logic signed [MUL_W-1:0]   ca, sa, cb, sb, cl, sl, co, so;
  logic signed [VEC_W-1:0]   x0, x2, t, aa, cc, zz, prod;
  logic                      res_inside, res_status;

  cordic_req_t             creq;
  cordic_rsp_t             crsp;
  logic signed [ANG_W-1:0] rot_ang;
  logic signed [MUL_W-1:0] opa, opb;
  logic signed [2*MUL_W-1:0] prod_full;
  logic                    accept, out_free;

  // Wrap a longitude difference into [-180, 180]
  function automatic logic signed [ANG_W-1:0] wrap(input logic signed [ANG_W-1:0] d);
    logic signed [ANG_W-1:0] w;
    w = d;
    if (w > DEG_HALF) w = w - DEG_FULL;
    if (w < -DEG_HALF) w = w + DEG_FULL;
    return w;
  endfunction

  // Saturating add into the running sum
  function automatic logic signed [SUM_W-1:0] sat_add(input logic signed [SUM_W-1:0] s,
                                                      input logic signed [ANG_W-1:0] d);
    logic signed [SUM_W:0] r;
    r = (SUM_W+1)'(s) + (SUM_W+1)'(d);
    if (r > SUM_MAX) r = SUM_MAX;
    if (r < SUM_MIN) r = SUM_MIN;
    return r[SUM_W-1:0];
  endfunction

  spip_cordic u_cordic (
    .clk    (clk),
    .rst    (rst),
    .req    (creq),
    .ang_in (rot_ang),
    .x_in   (zz),
    .y_in   (aa),
    .rsp    (crsp)
  );

  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // Angle for each sin/cos pass
  always_comb begin
    unique case (jsel)
      2'd0: rot_ang = ANG_W'(v_lat);
      2'd1: rot_ang = ANG_W'(v_lon);
      2'd2: rot_ang = ANG_W'(held_lat) - DEG_QUARTER;
      2'd3: rot_ang = ANG_W'(held_lon);
      default: rot_ang = '0;
    endcase
  end

  // Multiplier operands per product step
  always_comb begin
    unique case (k)
      3'd0: begin opa = ca;              opb = sb; end
      3'd1: begin opa = ca;              opb = cb; end
      3'd2: begin opa = x0[MUL_W-1:0];   opb = co; end
      3'd3: begin opa = x2[MUL_W-1:0];   opb = so; end
      3'd4: begin opa = x0[MUL_W-1:0];   opb = so; end
      3'd5: begin opa = x2[MUL_W-1:0];   opb = co; end
      3'd6: begin opa = sa;              opb = sl; end
      3'd7: begin opa = cc[MUL_W-1:0];   opb = cl; end
      default: begin opa = '0; opb = '0; end
    endcase
    prod_full = opa * opb;
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    creq       = '0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) state_next = (cnt < CNT_W'(MAX_VERTICES)) ? S_ROT : S_CHECK;
      end
      S_ROT: begin
        creq.start = 1'b1;
        state_next = S_ROT_WAIT;
      end
      S_ROT_WAIT: if (crsp.done) state_next = (jsel == 2'd3) ? S_MUL : S_ROT;
      S_MUL:      state_next = S_ACC;
      S_ACC:      state_next = (k == 3'd7) ? S_ATAN : S_MUL;
      S_ATAN: begin
        creq.start     = 1'b1;
        creq.vectoring = 1'b1;
        state_next     = S_ATAN_WAIT;
      end
      S_ATAN_WAIT: if (crsp.done) state_next = S_UPDATE;
      S_UPDATE:    state_next = S_CHECK;
      S_CHECK: begin
        if (!last_r)                  state_next = S_IDLE;
        else if (cnt < CNT_W'(2))     state_next = S_OUT;
        else                          state_next = S_CLOSE;
      end
      S_CLOSE:  state_next = S_DECIDE;
      S_DECIDE: state_next = S_OUT;
      S_OUT:    if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      sum      <= '0;
      m_tvalid <= 1'b0;
      jsel     <= '0;
      k        <= '0;
    end else begin
      // Raise the result item when the output is free, drop it once taken
      if (state == S_OUT && out_free) m_tvalid <= 1'b1;
      else if (m_tvalid && m_tready)  m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          jsel <= '0;
          k    <= '0;
        end
        S_ROT_WAIT: if (crsp.done) jsel <= jsel + 1'b1;
        S_ACC:      k <= k + 1'b1;
        S_UPDATE: begin
          if (cnt != '0) sum <= sat_add(sum, wrap(ANG_W'(lon_r) - ANG_W'(prev_lon)));
          cnt <= cnt + 1'b1;
        end
        S_CLOSE: sum <= sat_add(sum, wrap(ANG_W'(first_lon) - ANG_W'(prev_lon)));
        S_OUT: begin
          if (out_free) begin
            cnt      <= '0;
            sum      <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          v_lat  <= s_tdata[85:58];
          v_lon  <= s_tdata[115:86];
          last_r <= s_tlast;
          if (cnt == '0) begin
            held_lat <= s_tdata[27:0];
            held_lon <= s_tdata[57:28];
          end
        end
      end
      S_ROT_WAIT: begin
        if (crsp.done) begin
          unique case (jsel)
            2'd0: begin ca <= crsp.x[MUL_W-1:0]; sa <= crsp.y[MUL_W-1:0]; end
            2'd1: begin cb <= crsp.x[MUL_W-1:0]; sb <= crsp.y[MUL_W-1:0]; end
            2'd2: begin cl <= crsp.x[MUL_W-1:0]; sl <= crsp.y[MUL_W-1:0]; end
            2'd3: begin co <= crsp.x[MUL_W-1:0]; so <= crsp.y[MUL_W-1:0]; end
            default: ;
          endcase
        end
      end
      S_MUL: prod <= VEC_W'(prod_full >>> 30);
      S_ACC: begin
        unique case (k)
          3'd0: x0 <= prod;
          3'd1: x2 <= prod;
          3'd2: t  <= prod;
          3'd3: aa <= t - prod;
          3'd4: t  <= prod;
          3'd5: cc <= t + prod;
          3'd6: t  <= prod;
          3'd7: zz <= t + prod;
          default: ;
        endcase
      end
      S_ATAN_WAIT: if (crsp.done) lon_r <= crsp.z[LON_W-1:0];
      S_UPDATE: begin
        if (cnt == '0) first_lon <= lon_r;
        prev_lon <= lon_r;
      end
      S_CHECK: begin
        res_inside <= 1'b0;
        res_status <= (cnt < CNT_W'(2));
      end
      S_DECIDE: begin
        res_inside <= (((sum < 0) ? -(SUM_W+1)'(sum) : (SUM_W+1)'(sum)) > INSIDE_LIMIT);
      end
      S_OUT: if (out_free) m_tdata <= {6'b0, res_status, res_inside};
      default: ;
    endcase
  end

  // Checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(MAX_VERTICES)) else $error("vertex count beyond limit");

  a_done_waited: assert property (@(posedge clk) disable iff (rst)
    crsp.done |-> (state == S_ROT_WAIT || state == S_ATAN_WAIT))
    else $error("CORDIC result arrived with no pass pending");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready) else $error("second item taken while one is at work");

  a_error_not_inside: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1] |-> !m_tdata[0])
    else $error("too-few-vertices result also flagged inside");

endmodule
`default_nettype wire

// ----- tb/tb_spherical_point_in_polygon.sv -----
`default_nettype none
module tb_spherical_point_in_polygon;
  import spip_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint ANG_FULL    = 377487360;
  localparam longint ANG_HALF    = 188743680;
  localparam longint ANG_QUARTER = 94371840;
  localparam longint GAIN_Q30    = 652032874;
  localparam longint SUM_TOP     = 64'sd549755813887;
  localparam int     STALL_LIMIT = 20000;
  localparam int     RANDOM_ITEMS = 880;

  // Result status codes
  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_TOO_FEW  = 1'b1;

  typedef struct {
    logic signed [27:0] s_lat;
    logic signed [29:0] s_lon;
    logic signed [27:0] v_lat;
    logic signed [29:0] v_lon;
    logic               last;
  } vertex_item_t;

  typedef struct {
    logic in_poly;
    logic status;
  } verdict_t;

  typedef struct {
    vertex_item_t item;
    bit           typed;    // expected verdict given in the row
    verdict_t     want;
  } stim_row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [119:0] s_tdata = '0;
  logic         s_tlast = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [7:0]   m_tdata;

  spherical_point_in_polygon dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #5 clk = ~clk;

  // Predictor state
  longint pol_lat, pol_lon, first_lon, prev_lon, winding_sum;
  int     pol_count;

  verdict_t verdict_queue[$];
  int       mismatches = 0;
  int       verdicts_seen = 0;
  int       items_sent = 0;
  int       idle_cycles = 0;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;

  function automatic longint atan_entry(int i);
    longint tab[27] = '{47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658,
                        469357, 234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833, 917,
                        458, 229, 115, 57, 29, 14, 7, 4, 2, 1};
    return tab[i];
  endfunction

  // Arithmetic shift with floor rounding
  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint mul_q30(longint a, longint b);
    return (a * b) >>> 30;
  endfunction

  function automatic void rotate_sincos(input longint ang, output longint c,
                                        output longint s);
    longint r, x, y, nx;
    bit flip;
    r = ang % ANG_FULL;
    x = GAIN_Q30;
    y = 0;
    flip = 0;
    if (r < 0) r += ANG_FULL;
    if (r > ANG_HALF) r -= ANG_FULL;
    if (r > ANG_QUARTER) begin
      r -= ANG_HALF;
      flip = 1;
    end else if (r < -ANG_QUARTER) begin
      r += ANG_HALF;
      flip = 1;
    end
    for (int i = 0; i < 27; i++) begin
      if (r >= 0) begin
        nx = x - shr_floor(y, i); y = y + shr_floor(x, i); r -= atan_entry(i);
      end else begin
        nx = x + shr_floor(y, i); y = y - shr_floor(x, i); r += atan_entry(i);
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = x;
    s = y;
  endfunction

  function automatic longint vector_atan2(longint y, longint x);
    longint z, nx;
    z = 0;
    if (x < 0) begin
      z = (y >= 0) ? ANG_HALF : -ANG_HALF;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < 27; i++) begin
      if (y > 0) begin
        nx = x + shr_floor(y, i); y = y - shr_floor(x, i); z += atan_entry(i);
      end else if (y < 0) begin
        nx = x - shr_floor(y, i); y = y + shr_floor(x, i); z -= atan_entry(i);
      end else begin
        nx = x;
      end
      x = nx;
    end
    if (z > ANG_HALF) z = ANG_HALF;
    if (z < -ANG_HALF) z = -ANG_HALF;
    return z;
  endfunction

  // Longitude of a vertex seen from the sample point at the pole
  function automatic longint pole_longitude(longint vlat, longint vlon);
    longint ca, sa, cb, sb, cl, sl, co, so, x0, x1, x2, a, c, z;
    rotate_sincos(vlat, ca, sa);
    rotate_sincos(vlon, cb, sb);
    x0 = mul_q30(ca, sb);
    x1 = sa;
    x2 = mul_q30(ca, cb);
    rotate_sincos(pol_lat - ANG_QUARTER, cl, sl);
    rotate_sincos(pol_lon, co, so);
    a = mul_q30(x0, co) - mul_q30(x2, so);
    c = mul_q30(x0, so) + mul_q30(x2, co);
    z = mul_q30(x1, sl) + mul_q30(c, cl);
    return vector_atan2(a, z);
  endfunction

  function automatic longint wrap_half(longint d);
    if (d > ANG_HALF) d -= ANG_FULL;
    if (d < -ANG_HALF) d += ANG_FULL;
    return d;
  endfunction

  function automatic void add_winding(longint d);
    longint s;
    s = winding_sum + d;
    if (s > SUM_TOP) s = SUM_TOP;
    if (s < -SUM_TOP - 1) s = -SUM_TOP - 1;
    winding_sum = s;
  endfunction

  function automatic void clear_polygon();
    pol_lat = 0; pol_lon = 0; first_lon = 0; prev_lon = 0;
    winding_sum = 0; pol_count = 0;
  endfunction

  // Advance the predictor by one vertex; returns 1 when a verdict is due
  function automatic bit predict_vertex(vertex_item_t it, output verdict_t v);
    longint lon, mag;
    if (pol_count == 0) begin
      pol_lat = it.s_lat;
      pol_lon = it.s_lon;
    end
    if (pol_count < MAX_VERTICES) begin
      lon = pole_longitude(it.v_lat, it.v_lon);
      if (pol_count == 0) first_lon = lon;
      else add_winding(wrap_half(lon - prev_lon));
      prev_lon = lon;
      pol_count++;
    end
    if (!it.last) return 0;
    if (pol_count < 2) begin
      v.in_poly = 1'b0;
      v.status = STATUS_TOO_FEW;
    end else begin
      add_winding(wrap_half(first_lon - prev_lon));
      mag = winding_sum < 0 ? -winding_sum : winding_sum;
      v.in_poly = (mag > ANG_FULL - longint'(ANGLE_TOLERANCE));
      v.status = STATUS_OK;
    end
    clear_polygon();
    return 1;
  endfunction

  function automatic vertex_item_t make_item(longint sl, longint so, longint vl, longint vo,
                                             bit last);
    vertex_item_t it;
    it.s_lat = sl[27:0]; it.s_lon = so[29:0];
    it.v_lat = vl[27:0]; it.v_lon = vo[29:0];
    it.last = last;
    return it;
  endfunction

  // Send one vertex, honouring the sender idle rate; called at a falling edge
  task automatic send_vertex(vertex_item_t it, bit typed, verdict_t want);
    verdict_t v;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tdata  <= {4'b0, it.v_lon, it.v_lat, it.s_lon, it.s_lat};
    s_tlast  <= it.last;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
    if (predict_vertex(it, v)) begin
      if (typed && (v.in_poly !== want.in_poly || v.status !== want.status))
        $display("note: predictor disagrees with typed row at item %0d", items_sent);
      verdict_queue.push_back(typed ? want : v);
    end
    @(negedge clk);
  endtask

  // Receiver: random stalls, compare each verdict against the oldest prediction
  always @(negedge clk) begin
    if (!rst) m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (m_tvalid && m_tready) begin
        verdicts_seen++;
        if (verdict_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected verdict %b", m_tdata[1:0]);
        end else begin
          verdict_t w;
          w = verdict_queue.pop_front();
          if (m_tdata[0] !== w.in_poly || m_tdata[1] !== w.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("verdict %0d: expected inside=%b status=%b, got inside=%b status=%b",
                       verdicts_seen, w.in_poly, w.status, m_tdata[0], m_tdata[1]);
          end
        end
      end
    end
  end

  // Watchdog on accepted traffic
  always @(posedge clk) begin
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no traffic for %0d cycles", STALL_LIMIT);
      $display("FAILURE");
      $finish;
    end
  end

  // Directed table: extremes and special cases
  stim_row_t directed[$];

  task automatic add_row(longint sl, longint so, longint vl, longint vo, bit last,
                         bit typed = 0, logic ins = 0, logic st = 0);
    stim_row_t r;
    r.item = make_item(sl, so, vl, vo, last);
    r.typed = typed;
    r.want.in_poly = ins;
    r.want.status = st;
    directed.push_back(r);
  endtask

  // Random polygon around or away from the sample point
  task automatic random_polygon(int nverts);
    longint sl, so, cl, co, rad, vl, vo;
    verdict_t none;
    none = '{0, 0};
    sl = $urandom_range(0, 2 * ANG_QUARTER) - ANG_QUARTER;
    so = longint'($urandom_range(0, 2 * ANG_FULL)) - ANG_FULL;
    // centre near the sample half of the time so that inside verdicts occur
    if ($urandom_range(1)) begin
      cl = sl; co = so;
    end else begin
      cl = $urandom_range(0, 2 * ANG_QUARTER) - ANG_QUARTER;
      co = longint'($urandom_range(0, 2 * ANG_FULL)) - ANG_FULL;
    end
    rad = $urandom_range(1048576, 40 * 1048576);
    for (int k = 0; k < nverts; k++) begin
      longint ang;
      ang = (ANG_FULL * k) / nverts;
      vl = cl + (rad * ($urandom_range(0, 2000) - 1000)) / 1000 / 2;
      vo = co + ((ang < ANG_HALF) ? rad : -rad) * ($urandom_range(0, 1000)) / 1000;
      if ($urandom_range(9) == 0) begin
        vl = $urandom_range(0, 2 * ANG_QUARTER) - ANG_QUARTER;
        vo = longint'($urandom_range(0, 2 * ANG_FULL)) - ANG_FULL;
      end else begin
        // rotate a vertex around the centre
        vl = cl + (ang < ANG_HALF ? rad : -rad) / 2;
        vo = co + ((ang * 4 / ANG_FULL) % 2 == 0 ? rad : -rad);
        vl = cl + ((k % 4 == 0) ? rad : (k % 4 == 2) ? -rad : 0);
        vo = co + ((k % 4 == 1) ? rad : (k % 4 == 3) ? -rad : 0);
        vl += $urandom_range(0, 1000) - 500;
        vo += $urandom_range(0, 1000) - 500;
      end
      if (vl > ANG_QUARTER) vl = ANG_QUARTER;
      if (vl < -ANG_QUARTER) vl = -ANG_QUARTER;
      if (vo > ANG_FULL) vo = ANG_FULL;
      if (vo < -ANG_FULL) vo = -ANG_FULL;
      // random sample fields on later vertices are ignored by the block
      send_vertex(make_item(k == 0 ? sl : longint'($urandom_range(0, 2 * ANG_QUARTER)) - ANG_QUARTER,
                            k == 0 ? so : longint'($urandom_range(0, 2 * ANG_FULL)) - ANG_FULL,
                            vl, vo, k == nverts - 1), 0, none);
    end
  endtask

  initial begin
    int sent_random;
    int phase;
    clear_polygon();
    // One vertex alone: too few vertices
    add_row(0, 0, 0, 0, 1, 1, 1'b0, STATUS_TOO_FEW);
    add_row(ANG_QUARTER, ANG_FULL, -ANG_QUARTER, -ANG_FULL, 1, 1, 1'b0, STATUS_TOO_FEW);
    add_row(-ANG_QUARTER, -ANG_FULL, ANG_QUARTER, ANG_FULL, 1, 1, 1'b0, STATUS_TOO_FEW);
    // Square around the pole with the sample at the pole
    add_row(ANG_QUARTER, 0, 80 * 1048576, 0, 0);
    add_row(0, 0, 80 * 1048576, 90 * 1048576, 0);
    add_row(0, 0, 80 * 1048576, 180 * 1048576, 0);
    add_row(0, 0, 80 * 1048576, -90 * 1048576, 1);
    // Triangle away from the sample
    add_row(0, 0, 10 * 1048576, 10 * 1048576, 0);
    add_row(0, 0, 20 * 1048576, 10 * 1048576, 0);
    add_row(0, 0, 15 * 1048576, 20 * 1048576, 1);
    // Two vertices, degenerate; vertex equal to sample gives atan2 of zero vector
    add_row(-ANG_QUARTER, -ANG_FULL, -ANG_QUARTER, -ANG_FULL, 0);
    add_row(0, 0, ANG_QUARTER, ANG_FULL, 1);
    // Out-of-range extremes of the field widths
    add_row(-(1 << 27), -(1 << 29), (1 << 27) - 1, (1 << 29) - 1, 0);
    add_row((1 << 27) - 1, (1 << 29) - 1, -(1 << 27), -(1 << 29), 0);
    add_row(0, 0, 12345, -54321, 1);
    // Triangle around a mid-latitude sample, reversed winding
    add_row(30 * 1048576, 50 * 1048576, 35 * 1048576, 50 * 1048576, 0);
    add_row(0, 0, 27 * 1048576, 45 * 1048576, 0);
    add_row(0, 0, 27 * 1048576, 55 * 1048576, 1);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 0; recv_stall_pct = 0;
    foreach (directed[i]) send_vertex(directed[i].item, directed[i].typed, directed[i].want);

    sent_random = 0;
    phase = 0;
    while (sent_random < RANDOM_ITEMS) begin
      int n;
      case (phase % 5)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
        3: begin send_idle_pct = 22; recv_stall_pct = 22; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      phase++;
      for (int p = 0; p < 12 && sent_random < RANDOM_ITEMS; p++) begin
        n = ($urandom_range(19) == 0) ? 1 : $urandom_range(2, 12);
        random_polygon(n);
        sent_random += n;
      end
    end

    s_tvalid <= 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    while (verdict_queue.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("Ran %0d vertices (directed extremes and degenerate shapes, random polygons)",
             items_sent);
    $display("under mixed sender and receiver stalls; %0d verdicts checked", verdicts_seen);
    if (mismatches == 0 && verdict_queue.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAILURE");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- filelist.f -----
src/spip_pkg.sv
src/spip_cordic.sv
src/spherical_point_in_polygon.sv
tb/tb_spherical_point_in_polygon.sv
